// ----- rtl/lct_pkg.sv -----
package lct_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FX_W          = 32;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 16;
    localparam int PROJ_QUO_W    = 16;
    localparam int MAT_N         = 12;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_LINE = 1'b1;

    typedef logic signed [FX_W-1:0] fx_t;
    typedef fx_t [2:0]              vec3_t;
    typedef fx_t [MAT_N-1:0]        mat_t;

    typedef struct packed {
        vec3_t ta;
        vec3_t tb;
        logic  visible;
        logic  clip_a;
        logic  clip_b;
    } clip_side_t;

    typedef struct packed {
        logic visible;
        logic neg;
        logic ovf;
        logic nz;
    } proj_side_t;

    // signed screen coordinate from an unsigned quotient and its flags
    function automatic logic signed [COORD_W-1:0] coord_sat(
        input logic [PROJ_QUO_W-1:0] q,
        input proj_side_t            s
    );
        logic signed [COORD_W-1:0] r;
        if (!s.visible)
            r = '0;
        else if (s.ovf)
            r = !s.nz ? '0 : (s.neg ? 16'sh8000 : 16'sh7fff);
        else if (s.neg)
            r = (q > 16'd32768) ? 16'sh8000 : $signed(COORD_W'(~q + 16'd1));
        else
            r = (q > 16'd32767) ? 16'sh7fff : $signed(COORD_W'(q));
        return r;
    endfunction

endpackage

// ----- rtl/lct_if.sv -----
interface lct_seg_if;
    import lct_pkg::*;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [1:0]       row_index;
    logic signed [FX_W-1:0] a_x;
    logic signed [FX_W-1:0] a_y;
    logic signed [FX_W-1:0] a_z;
    logic signed [FX_W-1:0] b_x;
    logic signed [FX_W-1:0] b_y;
    logic signed [FX_W-1:0] b_z;

    modport source (output valid, opcode, row_index, a_x, a_y, a_z, b_x, b_y, b_z,
                    input ready);
    modport sink (input valid, opcode, row_index, a_x, a_y, a_z, b_x, b_y, b_z,
                  output ready);
endinterface

interface lct_res_if;
    import lct_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      visible;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;

    modport source (output valid, visible, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, visible, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- rtl/lct_div.sv -----
module lct_div #(
    parameter int NUM_W  = 47,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 16,
    parameter int SIDE_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);
    localparam int IW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    // restoring division, one quotient bit per stage, msb first
    logic [IW-1:0]     rem_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];
    logic              valid_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic [IW-1:0]     rem_in;
        logic [IW-1:0]     dsh;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_s;
        logic              valid_in;
        logic              fits;

        if (s == 0) begin : g_first
            assign rem_in   = IW'(num);
            assign den_in   = den;
            assign quo_in   = '0;
            assign side_s   = side_in;
            assign valid_in = in_valid;
        end else begin : g_next
            assign rem_in   = rem_reg[s-1];
            assign den_in   = den_reg[s-1];
            assign quo_in   = quo_reg[s-1];
            assign side_s   = side_reg[s-1];
            assign valid_in = valid_reg[s-1];
        end

        assign dsh  = IW'(den_in) << (QUO_W - 1 - s);
        assign fits = rem_in >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= fits ? rem_in - dsh : rem_in;
                den_reg[s]  <= den_in;
                quo_reg[s]  <= (quo_in << 1) | QUO_W'(fits);
                side_reg[s] <= side_s;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];
endmodule

// ----- rtl/lct_xform_lane.sv -----
module lct_xform_lane #(
    parameter int FRAC_BITS = lct_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  lct_pkg::vec3_t v,
    input  lct_pkg::mat_t  mat,
    output lct_pkg::vec3_t t
);
    import lct_pkg::*;

    localparam int PW = 2 * FX_W;
    localparam int SW = PW - FRAC_BITS + 2;

    logic signed [PW-1:0] prod_reg [3][3];
    fx_t                  tr_reg   [3];
    vec3_t                t_reg;
    vec3_t                t_next;
    logic signed [SW-1:0] sum      [3];

    // nine products of the endpoint against the axis rows
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                    prod_reg[c][k] <= $signed(v[k]) * $signed(mat[3*k + c]);
                tr_reg[c] <= mat[9 + c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = SW'($signed(tr_reg[c]))
                   + SW'(prod_reg[c][0] >>> FRAC_BITS)
                   + SW'(prod_reg[c][1] >>> FRAC_BITS)
                   + SW'(prod_reg[c][2] >>> FRAC_BITS);
            if (&sum[c][SW-1:FX_W-1] || ~|sum[c][SW-1:FX_W-1])
                t_next[c] = sum[c][FX_W-1:0];
            else
                t_next[c] = sum[c][SW-1] ? fx_t'(32'h8000_0000) : fx_t'(32'h7fff_ffff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t_reg <= t_next;
    end

    assign t = t_reg;
endmodule

// ----- rtl/line_transform_clip_project.sv -----
// channel | dir | payload                                    | handshake
// seg     | in  | opcode, row_index, a_x/y/z, b_x/y/z        | valid/ready
// res     | out | visible, start_x, start_y, end_x, end_y    | valid/ready
// cfg     | in  | cfg_we, cfg_index, cfg_data (write only)   | none
//
// one request per cycle while no result waits blocked at the output; a
// line result passes the clip divider (FRAC_BITS + 1 stages) and the
// projection dividers (16 stages)
// loads update the matrix at once and give no result
// reset: matrix to identity, viewport to 640 x 480, pipeline empty
// the whole pipeline holds only while the last stage has a result and the
// output register is full and not taken; bubbles in front hold as well
module line_transform_clip_project #(
    parameter int FRAC_BITS = lct_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [lct_pkg::DIM_W-1:0] cfg_data,
    lct_seg_if.sink                   seg,
    lct_res_if.source                 res
);
    import lct_pkg::*;

    localparam int CLIP_NUM_W  = FX_W - 1 + FRAC_BITS;
    localparam int CLIP_DEN_W  = FX_W;
    localparam int CLIP_QUO_W  = FRAC_BITS + 1;
    localparam int CLIP_PROD_W = FX_W + CLIP_QUO_W + 2;
    localparam int PROD_W      = FX_W + DIM_W + 1;
    localparam int PNUM_W      = PROD_W + 1;
    localparam int PDEN_W      = FX_W;
    localparam int SAT_W       = PDEN_W + PROJ_QUO_W;
    localparam logic [FX_W-1:0] ONE_FX = FX_W'(1 << FRAC_BITS);
    localparam logic [FX_W-1:0] NEAR_Z = FX_W'(((1 << FRAC_BITS) + 5) / 10);
    // identity axes, zero translation
    localparam mat_t MAT_RESET = {{(3*FX_W){1'b0}}, ONE_FX, {(3*FX_W){1'b0}}, ONE_FX,
                                  {(3*FX_W){1'b0}}, ONE_FX};

    // viewport and matrix
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    mat_t             mat_reg;
    mat_t             mat_next;

    logic en;
    logic accept;
    logic line_acc;

    // divider output valids
    logic       cdv;
    logic [3:0] pdv;

    // pipeline valids
    logic v1_reg, v2_reg, v3_reg, vc2_reg, vc3_reg, vp1_reg, vp2_reg;

    assign en       = !(pdv[0] && res.valid && !res.ready);
    assign seg.ready = en;
    assign accept   = seg.valid && en;
    assign line_acc = accept && (seg.opcode == OP_LINE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // matrix row write on a load request
    always_comb
    begin
        mat_next = mat_reg;
        if (accept && seg.opcode == OP_LOAD)
        begin
            mat_next[4'(seg.row_index) * 4'd3]        = seg.a_x;
            mat_next[4'(seg.row_index) * 4'd3 + 4'd1] = seg.a_y;
            mat_next[4'(seg.row_index) * 4'd3 + 4'd2] = seg.a_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_reg <= MAT_RESET;
        else
            mat_reg <= mat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vc2_reg <= 1'b0;
            vc3_reg <= 1'b0;
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= line_acc;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vc2_reg <= cdv;
            vc3_reg <= vc2_reg;
            vp1_reg <= vc3_reg;
            vp2_reg <= vp1_reg;
        end
    end

    // one transform lane per endpoint, products taken straight from the request
    vec3_t ta, tb;

    lct_xform_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_a (
        .clk (clk),
        .en  (en),
        .v   ({seg.a_z, seg.a_y, seg.a_x}),
        .mat (mat_reg),
        .t   (ta)
    );

    lct_xform_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
        .clk (clk),
        .en  (en),
        .v   ({seg.b_z, seg.b_y, seg.b_x}),
        .mat (mat_reg),
        .t   (tb)
    );

    // merge: cull decision and near-plane clip setup
    logic                  clip_a_c, clip_b_c, culled_c;
    logic [FX_W-1:0]       pz_c, qz_c;
    logic [FX_W:0]         zdiff_c;
    logic [CLIP_NUM_W-1:0] cnum_next, cnum_reg;
    logic [CLIP_DEN_W-1:0] cden_next, cden_reg;
    clip_side_t            cside_next, cside_reg;

    always_comb
    begin
        clip_a_c = ta[2][FX_W-1] & ~tb[2][FX_W-1];
        clip_b_c = tb[2][FX_W-1] & ~ta[2][FX_W-1];
        culled_c = ta[2][FX_W-1] & tb[2][FX_W-1];
        pz_c     = clip_a_c ? ta[2] : tb[2];
        qz_c     = clip_a_c ? tb[2] : ta[2];
        zdiff_c  = {qz_c[FX_W-1], qz_c} - {pz_c[FX_W-1], pz_c};
        // no clip: divide zero by one so the divider stays in range
        if (clip_a_c || clip_b_c)
        begin
            cnum_next = {qz_c[FX_W-2:0], {FRAC_BITS{1'b0}}};
            cden_next = zdiff_c[FX_W-1:0];
        end
        else
        begin
            cnum_next = '0;
            cden_next = CLIP_DEN_W'(1);
        end
        cside_next = '{ta: ta, tb: tb, visible: !culled_c, clip_a: clip_a_c, clip_b: clip_b_c};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnum_reg  <= cnum_next;
            cden_reg  <= cden_next;
            cside_reg <= cside_next;
        end
    end

    // clip fraction d = zin / (zin - zout) in fixed point
    logic [CLIP_QUO_W-1:0] cquo;
    logic [$bits(clip_side_t)-1:0] cside_raw;
    clip_side_t            cs;

    lct_div #(
        .NUM_W  (CLIP_NUM_W),
        .DEN_W  (CLIP_DEN_W),
        .QUO_W  (CLIP_QUO_W),
        .SIDE_W ($bits(clip_side_t))
    ) u_clip_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .num       (cnum_reg),
        .den       (cden_reg),
        .side_in   (cside_reg),
        .out_valid (cdv),
        .quo       (cquo),
        .side_out  (cside_raw)
    );

    assign cs = clip_side_t'(cside_raw);

    // interpolation products (p - q) * d
    vec3_t                   p_c, q_c;
    logic [FX_W:0]           dx_c, dy_c;
    logic signed [CLIP_PROD_W-1:0] mx_reg, my_reg;
    fx_t                     qx_reg, qy_reg;
    clip_side_t              c2side_reg;

    always_comb
    begin
        p_c  = cs.clip_a ? cs.ta : cs.tb;
        q_c  = cs.clip_a ? cs.tb : cs.ta;
        dx_c = {p_c[0][FX_W-1], p_c[0]} - {q_c[0][FX_W-1], q_c[0]};
        dy_c = {p_c[1][FX_W-1], p_c[1]} - {q_c[1][FX_W-1], q_c[1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg     <= $signed(dx_c) * $signed({1'b0, cquo});
            my_reg     <= $signed(dy_c) * $signed({1'b0, cquo});
            qx_reg     <= q_c[0];
            qy_reg     <= q_c[1];
            c2side_reg <= cs;
        end
    end

    // clipped endpoint onto the near plane
    fx_t   nx_c, ny_c;
    vec3_t ea_reg, eb_reg;
    logic  vis3_reg;

    assign nx_c = qx_reg + FX_W'(mx_reg >>> FRAC_BITS);
    assign ny_c = qy_reg + FX_W'(my_reg >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ea_reg   <= c2side_reg.clip_a ? {NEAR_Z, ny_c, nx_c} : c2side_reg.ta;
            eb_reg   <= c2side_reg.clip_b ? {NEAR_Z, ny_c, nx_c} : c2side_reg.tb;
            vis3_reg <= c2side_reg.visible;
        end
    end

    // projection products per endpoint
    vec3_t                    e_c [2];
    logic signed [PROD_W-1:0] xh_reg [2];
    logic signed [PROD_W-1:0] wz_reg [2];
    logic signed [PROD_W-1:0] hz_reg [2];
    logic signed [PROD_W-1:0] yh_reg [2];
    fx_t                      z_reg  [2];
    logic                     vis_p1_reg;

    assign e_c[0] = ea_reg;
    assign e_c[1] = eb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 2; e++)
            begin
                xh_reg[e] <= $signed(e_c[e][0]) * $signed({1'b0, height_reg});
                wz_reg[e] <= $signed(e_c[e][2]) * $signed({1'b0, width_reg});
                hz_reg[e] <= $signed(e_c[e][2]) * $signed({1'b0, height_reg});
                yh_reg[e] <= $signed(e_c[e][1]) * $signed({1'b0, height_reg});
                z_reg[e]  <= e_c[e][2];
            end
            vis_p1_reg <= vis3_reg;
        end
    end

    // numerators, sign, magnitude and saturation check per coordinate
    // lanes: start x, start y, end x, end y
    logic signed [PNUM_W-1:0] pn_c    [4];
    logic [PNUM_W-1:0]        mag_c   [4];
    logic [PDEN_W-1:0]        pd_c    [4];
    proj_side_t               ps_c    [4];
    logic [PNUM_W-1:0]        pnum_reg  [4];
    logic [PDEN_W-1:0]        pden_reg  [4];
    proj_side_t               pside_reg [4];

    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            pn_c[2*e]     = PNUM_W'(xh_reg[e]) + PNUM_W'(wz_reg[e]);
            pn_c[2*e + 1] = PNUM_W'(hz_reg[e]) - PNUM_W'(yh_reg[e]);
            pd_c[2*e]     = {z_reg[e][FX_W-2:0], 1'b0};
            pd_c[2*e + 1] = {z_reg[e][FX_W-2:0], 1'b0};
        end
        for (int i = 0; i < 4; i++)
        begin
            mag_c[i]      = pn_c[i][PNUM_W-1] ? ~pn_c[i] + PNUM_W'(1) : pn_c[i];
            ps_c[i].visible = vis_p1_reg;
            ps_c[i].neg   = pn_c[i][PNUM_W-1];
            ps_c[i].nz    = |pn_c[i];
            // a zero divisor always lands here
            ps_c[i].ovf   = SAT_W'(mag_c[i]) >= (SAT_W'(pd_c[i]) << PROJ_QUO_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pnum_reg[i]  <= ps_c[i].ovf ? '0 : mag_c[i];
                pden_reg[i]  <= ps_c[i].ovf ? PDEN_W'(1) : pd_c[i];
                pside_reg[i] <= ps_c[i];
            end
        end
    end

    // four projection divider lanes
    logic [PROJ_QUO_W-1:0] pquo [4];
    logic [$bits(proj_side_t)-1:0] pside_raw [4];

    for (genvar i = 0; i < 4; i++) begin : g_proj
        lct_div #(
            .NUM_W  (PNUM_W),
            .DEN_W  (PDEN_W),
            .QUO_W  (PROJ_QUO_W),
            .SIDE_W ($bits(proj_side_t))
        ) u_proj_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vp2_reg),
            .num       (pnum_reg[i]),
            .den       (pden_reg[i]),
            .side_in   (pside_reg[i]),
            .out_valid (pdv[i]),
            .quo       (pquo[i]),
            .side_out  (pside_raw[i])
        );
    end

    // output register
    logic                      res_valid_reg, res_valid_next;
    logic                      visible_reg;
    logic signed [COORD_W-1:0] coord_reg [4];
    proj_side_t                pso0;

    assign pso0 = proj_side_t'(pside_raw[0]);

    always_comb
    begin
        if (en && pdv[0])
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && pdv[0])
        begin
            visible_reg <= pso0.visible;
            for (int i = 0; i < 4; i++)
                coord_reg[i] <= coord_sat(pquo[i], proj_side_t'(pside_raw[i]));
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.visible = visible_reg;
    assign res.start_x = coord_reg[0];
    assign res.start_y = coord_reg[1];
    assign res.end_x   = coord_reg[2];
    assign res.end_y   = coord_reg[3];
endmodule

// ----- rtl/lct_check.sv -----
module lct_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        visible,
    input logic [15:0] start_x,
    input logic [15:0] start_y,
    input logic [15:0] end_x,
    input logic [15:0] end_y
);
    // a waiting result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while waiting");

    // requests are refused only behind a blocked result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request refused without a blocked result");

    // taking the result frees the request side
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("request side blocked while result taken");

    // culled lines carry zero coordinates
    a_cull: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |->
            start_x == 16'd0 && start_y == 16'd0 && end_x == 16'd0 && end_y == 16'd0)
        else $error("culled line with nonzero coordinates");
endmodule

bind line_transform_clip_project lct_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (seg.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .visible   (res.visible),
    .start_x   (res.start_x),
    .start_y   (res.start_y),
    .end_x     (res.end_x),
    .end_y     (res.end_y)
);
